### rtl/core/aes_ige_pkg.sv
// Shared types, S-box tables and GF(2^8) helpers for the AES-256 IGE cipher.
package aes_ige_pkg;

  localparam int NumWords = 60;
  localparam int NumRounds = 14;
  localparam int NumRegs = 8;
  // Four-word steps from the key window (words 0..7) to the last window (words 52..59)
  localparam int ExpandSteps = (NumWords - 8) / 4;

  typedef logic [3:0] round_t;

  typedef enum logic [1:0] {
    FUNC_ENC     = 2'd0,
    FUNC_DEC     = 2'd1,
    FUNC_IGE_ENC = 2'd2,
    FUNC_IGE_DEC = 2'd3
  } func_t;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IV0  = 3'd4;
  localparam logic [2:0] REG_IV1  = 3'd5;
  localparam logic [2:0] REG_IV2  = 3'd6;
  localparam logic [2:0] REG_IV3  = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input block, apply whitening key
    logic round;      // run one round
    logic last;       // final round (no column mix)
    logic finish;     // update IGE chain once result is taken
    round_t rnd;      // round number for key fetch
  } dp_cmd_t;

  // Key schedule controller commands
  typedef struct packed {
    logic start;      // restart expansion
    logic step;       // advance expansion by four words
    logic advance;    // move both round key windows on by one round
    logic rewind;     // return both round key windows to round zero
  } ks_cmd_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ p;
      p = xt(p);
    end
    gm = r;
  endfunction

  function automatic logic [7:0] mulx(input logic [7:0] a, input int n);
    logic [7:0] r;
    r = a;
    for (int i = 0; i < 8; i++) if (i < n) r = xt(r);
    mulx = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] a);
    // a^254 by square and multiply
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] q;
    r = 8'h01;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) begin
        q = 8'h00;
        for (int j = 0; j < 8; j++) if (p[j]) q = q ^ mulx(r, j);
        r = q;
      end
      q = 8'h00;
      for (int j = 0; j < 8; j++) if (p[j]) q = q ^ mulx(p, j);
      p = q;
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] v;
    logic [7:0] s;
    logic [7:0] r;
    v = ginv(x);
    s = v;
    r = v;
    for (int t = 0; t < 4; t++) begin
      r = {r[6:0], r[7]};
      s = s ^ r;
    end
    sbox_calc = s ^ 8'h63;
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t make_sbox();
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    return t;
  endfunction

  function automatic sbox_arr_t make_inv_sbox();
    sbox_arr_t t;
    logic [7:0] s;
    for (int i = 0; i < 256; i++) begin
      s = sbox_calc(8'(i));
      t[s] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_arr_t SBOX = make_sbox();
  localparam sbox_arr_t INV_SBOX = make_inv_sbox();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    inv_mix_word = {gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9),
                    gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13),
                    gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11),
                    gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14)};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    mix_word = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

endpackage

### rtl/core/aes_ige_if.sv
// Valid/ready channel interfaces for input blocks and results.
interface aes_ige_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        first_block;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, func, first_block, block_hi, block_lo, input ready);
  modport sink (input valid, func, first_block, block_hi, block_lo, output ready);
endinterface

interface aes_ige_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

### rtl/core/aes_ige_keysched.sv
// Key schedule: eight-word windows stepped forward for encryption and backward for decryption.
module aes_ige_keysched
  import aes_ige_pkg::*;
(
  input  logic           clk,
  input  ks_cmd_t        cmd,
  input  logic [255:0]   key,
  input  round_t         rnd,
  output logic           done,
  output logic [127:0]   enc_key,
  output logic [127:0]   dec_key
);

  // Windows hold eight consecutive schedule words, lowest word in the top bits
  logic [255:0] ewin;
  logic [255:0] dwin;
  logic [255:0] dend;
  logic [3:0]   xcnt;
  logic [3:0]   ecnt;
  logic [3:0]   dcnt;

  // Next four words after the window; n counts steps from the key window
  function automatic logic [255:0] key_fwd(input logic [255:0] w, input logic [3:0] n);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    if (!n[0]) t = sub_word({w[23:0], w[31:24]}) ^ {8'h01 << n[3:1], 24'h0};
    else t = sub_word(w[31:0]);
    n0 = w[255:224] ^ t;
    n1 = w[223:192] ^ n0;
    n2 = w[191:160] ^ n1;
    n3 = w[159:128] ^ n2;
    key_fwd = {w[127:0], n0, n1, n2, n3};
  endfunction

  // Four words before the window; n counts steps back from the last window
  function automatic logic [255:0] key_bwd(input logic [255:0] w, input logic [3:0] n);
    logic [31:0] t;
    if (!n[0]) t = sub_word({w[151:128], w[159:152]}) ^ {8'h01 << (3'd6 - n[3:1]), 24'h0};
    else t = sub_word(w[159:128]);
    key_bwd = {w[127:96] ^ t, w[95:64] ^ w[127:96], w[63:32] ^ w[95:64],
               w[31:0] ^ w[63:32], w[255:128]};
  endfunction

  assign done = (xcnt == 4'(ExpandSteps));

  // Load key and expand to the last window; then step the round windows
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ewin <= key;
      dwin <= key;
      xcnt <= '0;
      ecnt <= '0;
      dcnt <= '0;
    end else if (cmd.step && !done) begin
      dwin <= key_fwd(dwin, xcnt);
      dend <= key_fwd(dwin, xcnt);
      xcnt <= xcnt + 4'd1;
    end else if (cmd.rewind) begin
      ewin <= key;
      dwin <= dend;
      ecnt <= '0;
      dcnt <= '0;
    end else if (cmd.advance) begin
      ewin <= key_fwd(ewin, ecnt);
      dwin <= key_bwd(dwin, dcnt);
      ecnt <= ecnt + 4'd1;
      dcnt <= dcnt + 4'd1;
    end
  end

  // Round keys; inverse key uses mixed words for middle rounds
  assign enc_key = ewin[255:128];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (rnd == '0 || rnd == round_t'(NumRounds))
        dec_key[127 - 32*c -: 32] = dwin[127 - 32*c -: 32];
      else
        dec_key[127 - 32*c -: 32] = inv_mix_word(dwin[127 - 32*c -: 32]);
    end
  end

endmodule

### rtl/core/aes_ige_datapath.sv
// Round datapath: state register, shared round unit and IGE chain registers.
module aes_ige_datapath
  import aes_ige_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  dp_cmd_t        cmd,
  input  func_t          func,
  input  logic           first_block,
  input  logic [127:0]   blk,
  input  logic [255:0]   iv,
  input  logic [127:0]   enc_key,
  input  logic [127:0]   dec_key,
  output logic [127:0]   result
);

  logic [127:0] state;
  logic [127:0] prev_c;
  logic [127:0] prev_p;
  logic [127:0] in_blk;
  logic [127:0] cur_c;
  logic [127:0] cur_p;
  logic [127:0] rkey;
  logic [127:0] sr;
  logic [127:0] mx;
  logic [127:0] rnd_out;
  logic         dec;
  logic         ige;
  func_t        func_q;
  logic [127:0] blk_q;
  logic [7:0]   b [16];
  logic [7:0]   s [16];

  assign dec = func_q[0];
  assign ige = func_q[1];
  assign rkey = dec ? dec_key : enc_key;

  // Chain values in effect for this block
  assign cur_c = (first_block && func[1]) ? iv[255:128] : prev_c;
  assign cur_p = (first_block && func[1]) ? iv[127:0] : prev_p;

  always_comb begin
    case (func)
      FUNC_IGE_ENC: in_blk = blk ^ cur_c;
      FUNC_IGE_DEC: in_blk = blk ^ cur_p;
      default:      in_blk = blk;
    endcase
  end

  // One round: substitute, shift rows, mix columns (skipped in the last round), add key; inverse steps when decrypting
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      b[k] = dec ? INV_SBOX[state[127 - 8*k -: 8]] : SBOX[state[127 - 8*k -: 8]];
    end
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) begin
        if (dec) s[((c + k) % 4) * 4 + k] = b[c*4 + k];
        else s[c*4 + k] = b[((c + k) % 4) * 4 + k];
      end
    for (int k = 0; k < 16; k++) begin
      sr[127 - 8*k -: 8] = s[k];
    end
    for (int c = 0; c < 4; c++)
      mx[127 - 32*c -: 32] = dec ? inv_mix_word(sr[127 - 32*c -: 32])
                                 : mix_word(sr[127 - 32*c -: 32]);
    rnd_out = (cmd.last ? sr : mx) ^ rkey;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state  <= in_blk ^ (func[0] ? dec_key : enc_key);
      func_q <= func;
      blk_q  <= blk;
    end else if (cmd.round) begin
      state <= rnd_out;
    end
  end

  assign result = !ige ? state :
                  (dec ? state ^ prev_c : state ^ prev_p);

  // Hold chain; reload from IV on first block, update at finish
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_c <= '0;
      prev_p <= '0;
    end else if (cmd.load) begin
      prev_c <= cur_c;
      prev_p <= cur_p;
    end else if (cmd.finish && ige) begin
      if (dec) begin
        prev_c <= blk_q;
        prev_p <= state ^ prev_c;
      end else begin
        prev_c <= state ^ prev_p;
        prev_p <= blk_q;
      end
    end
  end

endmodule

### rtl/core/aes_ige_ctrl.sv
// Controller: key expansion sequencing, round counting and handshakes.
module aes_ige_ctrl
  import aes_ige_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     key_write,
  input  logic     ks_done,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ks_cmd_t  ks_cmd,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [3:0] {
    ST_KEYX = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  round_t rnd, rnd_next;
  logic   pend;

  // Next state and commands
  always_comb begin
    state_next = state;
    rnd_next = rnd;
    in_ready = 1'b0;
    out_valid = 1'b0;
    ks_cmd = '0;
    dp_cmd = '0;
    dp_cmd.rnd = rnd;
    case (state)
      ST_KEYX: begin
        ks_cmd.step = 1'b1;
        if (ks_done && !pend) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        dp_cmd.rnd = '0;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          rnd_next = round_t'(1);
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        dp_cmd.round = 1'b1;
        dp_cmd.last = (rnd == round_t'(NumRounds));
        rnd_next = rnd + round_t'(1);
        if (rnd == round_t'(NumRounds)) state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          dp_cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_KEYX;
    endcase
    // Restart expansion the cycle after a key write, once the new key is held
    if (pend) ks_cmd.start = 1'b1;
    ks_cmd.advance = dp_cmd.load | dp_cmd.round;
    ks_cmd.rewind = dp_cmd.finish;
  end

  // Advance; restart expansion on key write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KEYX;
      rnd <= '0;
      pend <= 1'b1;
    end else begin
      state <= key_write ? ST_KEYX : state_next;
      rnd <= rnd_next;
      pend <= key_write;
    end
  end

endmodule

### rtl/core/aes256_ige_cipher.sv
// Top level of the AES-256 IGE cipher.
// Blocks are taken one at a time: the single round unit and the chaining serialise blocks,
// so a new block is accepted only after the previous result has been taken.
// Reset: synchronous; clears keys, IVs and chain to zero, then expands the key schedule
// before the first block is taken. A key write repeats the expansion.
module aes256_ige_cipher
  import aes_ige_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  aes_ige_in_if.sink   in_ch,
  aes_ige_out_if.source out_ch
);

  logic [63:0]  regs [NumRegs];
  ks_cmd_t      ks_cmd;
  dp_cmd_t      dp_cmd;
  logic         ks_done;
  logic         key_write;
  logic [127:0] enc_key, dec_key, result;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign key_write = cfg_we && !cfg_index[2];

  aes_ige_ctrl u_ctrl (
    .clk, .rst, .key_write, .ks_done,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .ks_cmd, .dp_cmd
  );

  aes_ige_keysched u_ks (
    .clk, .cmd(ks_cmd),
    .key({regs[REG_KEY0], regs[REG_KEY1], regs[REG_KEY2], regs[REG_KEY3]}),
    .rnd(dp_cmd.rnd), .done(ks_done), .enc_key, .dec_key
  );

  aes_ige_datapath u_dp (
    .clk, .rst, .cmd(dp_cmd),
    .func(func_t'(in_ch.func)), .first_block(in_ch.first_block),
    .blk({in_ch.block_hi, in_ch.block_lo}),
    .iv({regs[REG_IV0], regs[REG_IV1], regs[REG_IV2], regs[REG_IV3]}),
    .enc_key, .dec_key, .result
  );

  assign out_ch.result_hi = result[127:64];
  assign out_ch.result_lo = result[63:0];

endmodule
